// ===== src/b2t_pkg.sv =====
// Shared constants and types for the 3-to-4 binary-to-text encoder.
package b2t_pkg;

  // Characters per output line before a newline is inserted (4..256)
  localparam int LINE_CHARS = 64;

  localparam int BYTE_W  = 8;
  localparam int CHAR_W  = 7;
  localparam int FIELD_W = 6;
  localparam int LINE_W  = 8;

  localparam logic [CHAR_W-1:0] CHAR_BIAS = 7'h20;
  localparam logic [CHAR_W-1:0] NEWLINE   = 7'h0A;

  // Group queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Words per group: four characters, then up to two newlines
  localparam logic [2:0] GROUP_CHARS = 3'd4;

  // One completed group as handed from front to back
  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic              line_nl;   // line is full after this group
    logic              close_nl;  // stream ends after this group
  } grp_t;

endpackage

// ===== src/b2t_front.sv =====
// Front end: collect bytes into groups of three and track the line length.
module b2t_front
  import b2t_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last_byte,
  output logic              q_push,
  output grp_t              q_wdata,
  input  logic              q_full
);

  logic [1:0]        phase_r;
  logic [BYTE_W-1:0] held0_r;
  logic [BYTE_W-1:0] held1_r;
  logic [LINE_W-1:0] line_cnt_r;

  logic              accept;
  logic              complete;
  logic [LINE_W:0]   cnt_sum;
  logic              line_full;

  // Hold off input while the group queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  // A byte closes the group at phase two (or three) or at end of stream
  assign complete = in_last_byte || phase_r[1];

  assign cnt_sum   = {1'b0, line_cnt_r} + (LINE_W+1)'(4);
  assign line_full = cnt_sum >= (LINE_W+1)'(LINE_CHARS);

  // Assemble the group, taking missing bytes as zero
  always_comb begin
    q_wdata.b0       = (phase_r == 2'd0) ? in_data_byte : held0_r;
    q_wdata.b1       = (phase_r == 2'd0) ? '0 :
                       (phase_r == 2'd1) ? in_data_byte : held1_r;
    q_wdata.b2       = phase_r[1] ? in_data_byte : '0;
    q_wdata.line_nl  = line_full;
    q_wdata.close_nl = in_last_byte;
  end

  assign q_push = accept && complete;

  // Advance phase on each accepted word, and the line count on each completed group
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= 2'd0;
      line_cnt_r <= '0;
    end else if (accept) begin
      if (complete) begin
        phase_r <= 2'd0;
        if (in_last_byte || line_full) begin
          line_cnt_r <= '0;
        end else begin
          line_cnt_r <= cnt_sum[LINE_W-1:0];
        end
      end else begin
        phase_r <= phase_r + 2'd1;
      end
    end
  end

  // Capture held bytes
  always_ff @(posedge clk) begin
    if (accept && !complete) begin
      if (phase_r == 2'd0) begin
        held0_r <= in_data_byte;
      end else begin
        held1_r <= in_data_byte;
      end
    end
  end

endmodule

// ===== src/b2t_queue.sv =====
// Two-entry group queue between the front and back ends.
module b2t_queue
  import b2t_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t wdata,
  output logic full,
  input  logic pop,
  output grp_t rdata,
  output logic nonempty
);

  grp_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr_r;
  logic [QPTR_W-1:0] rptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full     = count_r == QCNT_W'(QDEPTH);
  assign nonempty = count_r != '0;
  assign rdata    = mem[rptr_r];

  // Write an entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rptr_r <= rptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

endmodule

// ===== src/b2t_back.sv =====
// Back end: turn each group into characters and newlines, one word per cycle while not stalled.
module b2t_back
  import b2t_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  grp_t              q_rdata,
  input  logic              q_nonempty,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last_char
);

  grp_t              cur_r;
  logic              cur_valid_r;
  logic [2:0]        step_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  logic              adv;
  logic              emit;
  logic              final_word;
  logic              done;
  logic [2:0]        n_words;
  logic [FIELD_W-1:0] field;
  logic [CHAR_W-1:0] char_nxt;

  assign adv  = !out_valid_r || !out_stall;
  assign emit = adv && cur_valid_r;

  assign n_words    = GROUP_CHARS + {2'b00, cur_r.line_nl} + {2'b00, cur_r.close_nl};
  assign final_word = step_r == (n_words - 3'd1);
  assign done       = emit && final_word;
  assign q_pop      = q_nonempty && (!cur_valid_r || done);

  // Pick the 6-bit field for this step, then bias it or send a newline
  always_comb begin
    unique case (step_r[1:0])
      2'd0:    field = cur_r.b0[5:0];
      2'd1:    field = {cur_r.b1[3:0], cur_r.b0[7:6]};
      2'd2:    field = {cur_r.b2[1:0], cur_r.b1[7:4]};
      default: field = cur_r.b2[7:2];
    endcase
    if (step_r[2]) begin
      char_nxt = NEWLINE;
    end else begin
      char_nxt = {1'b0, field} + CHAR_BIAS;
    end
  end

  // Load the next group and step through its words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      step_r      <= '0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
      step_r      <= '0;
    end else if (done) begin
      cur_valid_r <= 1'b0;
    end else if (emit) begin
      step_r <= step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
  end

  // Output register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= cur_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= char_nxt;
      out_last_r <= final_word;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

endmodule

// ===== src/binary_to_text_3to4_encoder_unit.sv =====
// Top level of the 3-to-4 binary-to-text encoder.
// Bytes enter one per word, least significant bits first, and every three
// bytes (or the final partial group, padded with zero bytes) leave as four
// printable characters 0x20..0x5F, with a newline after each LINE_CHARS
// characters and one closing newline at end of stream; last_char marks the
// final word of each group. The front end takes one byte per cycle as long
// as its two-entry group queue has room; the back end sends one word per
// cycle from its output register while out_stall is low, so a group takes
// four to six words there and a long stream's rate is set by that single
// output port. There is no clearing pass after reset.
module binary_to_text_3to4_encoder_unit
  import b2t_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_data_byte,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last_char
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_nonempty;
  grp_t q_wdata;
  grp_t q_rdata;

  b2t_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_push       (q_push),
    .q_wdata      (q_wdata),
    .q_full       (q_full)
  );

  b2t_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .pop      (q_pop),
    .rdata    (q_rdata),
    .nonempty (q_nonempty)
  );

  b2t_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_rdata       (q_rdata),
    .q_nonempty    (q_nonempty),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule

// ===== src/b2t_checker.sv =====
// Port-level checks for the encoder, bound to the top level.
module b2t_checker
  import b2t_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [BYTE_W-1:0] in_data_byte,
  input logic              in_last_byte,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CHAR_W-1:0] out_char,
  input logic              out_last_char
);

  // Nothing leaves in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word shown right after reset");

  // Stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_char) && $stable(out_last_char))
    else $error("stalled output word changed");

  // Every word is a newline or a biased 6-bit field
  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char == NEWLINE) ||
                  (out_char >= CHAR_BIAS && out_char <= 7'h5F))
    else $error("output character out of range");

  // Stalled input word holds until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=>
      in_valid && $stable(in_data_byte) && $stable(in_last_byte))
    else $error("stalled input word changed");

endmodule

bind binary_to_text_3to4_encoder_unit b2t_checker u_b2t_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_data_byte  (in_data_byte),
  .in_last_byte  (in_last_byte),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_char      (out_char),
  .out_last_char (out_last_char)
);
